// ===== rtl/lrupc_pkg.sv =====
// shared constants, types and codes for the lru page cache lookup block
// no dependencies; imported by the top level
package lrupc_pkg;

	localparam int MAX_PAGES  = 8;
	localparam int SLOT_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int USED_W     = $clog2(MAX_PAGES + 1);
	localparam int PAGE_W     = 24;
	localparam int ROW_W      = 24;
	localparam int PSIZE_W    = 16;
	localparam int PROD_W     = ROW_W + PSIZE_W;
	localparam int CNT_W      = $clog2(ROW_W + 1);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [PSIZE_W-1:0] DEFAULT_PAGE_SIZE = PSIZE_W'(60);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAGE_SIZE = 1'b0,
		REG_ROW_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_CLEAR  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic               in_range;
		logic               hit;
		logic [PAGE_W-1:0]  page_number;
		logic [PSIZE_W-1:0] offset_in_page;
		logic               fetch_needed;
		logic [ROW_W-1:0]   fetch_offset;
		logic               evicted_valid;
		logic [PAGE_W-1:0]  evicted_page;
	} result_t;

endpackage

// ===== rtl/lru_page_cache_lookup.sv =====
// top level of the lru page cache lookup block: sequencer, divider, tag scan
// depends on lrupc_pkg and lrupc_ram
//
// Page lookup cache with least-recently-used replacement. Each request
// transaction carries a command and a row index. A lookup splits the row
// into page (row / page_size) and offset (row % page_size); a page size
// register of zero acts as 60. A row at or beyond row_count is rejected
// with all response fields zero and no change to the cache. A hit makes
// the page most recent; a miss asks for a fetch at page * page_size and
// inserts the page, evicting and reporting the least recently used page
// when all eight entries are in use. A clear empties the cache and, when
// row_count is nonzero, primes page 0 with a fetch. Every request gives
// exactly one response transaction. A rejected lookup or a clear goes
// straight to the output step; an accepted lookup runs the restoring
// divider (one quotient bit per cycle), a multiply step and a scan of
// the tag ram (one entry per cycle, through its registered read port),
// followed by an update step. One request is worked on at a time; the
// next one is accepted as soon as the previous response sits in the
// output register, even if the consumer has not yet taken it.
// Configuration writes are always accepted and must only be issued while
// the block is idle.
module lru_page_cache_lookup (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lrupc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lrupc_pkg::CFG_DATA_W-1:0]  cfg_data,
	// request channel
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic                              command,
	input  logic [lrupc_pkg::ROW_W-1:0]       row_index,
	// response channel
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic                              in_range,
	output logic                              hit,
	output logic [lrupc_pkg::PAGE_W-1:0]      page_number,
	output logic [lrupc_pkg::PSIZE_W-1:0]     offset_in_page,
	output logic                              fetch_needed,
	output logic [lrupc_pkg::ROW_W-1:0]       fetch_offset,
	output logic                              evicted_valid,
	output logic [lrupc_pkg::PAGE_W-1:0]      evicted_page
);

	import lrupc_pkg::*;

	// one-hot sequencer states
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DIV  = 6'b000010,
		S_MUL  = 6'b000100,
		S_SCAN = 6'b001000,
		S_UPD  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [PSIZE_W-1:0] page_size_q;
	logic [ROW_W-1:0]   row_count_q;

	// per-entry control state kept in flops (tags live in the ram)
	logic [MAX_PAGES-1:0] valid_q;
	logic [SLOT_W-1:0]    rank_q [MAX_PAGES];
	logic [USED_W-1:0]    used_q;

	// divider: div_q starts as the row and ends as the page number
	logic [ROW_W-1:0]   row_q;
	logic [ROW_W-1:0]   div_q;
	logic [PSIZE_W-1:0] rem_q;
	logic [PSIZE_W-1:0] ps_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PSIZE_W:0]   rem_shift;
	logic               rem_ge;

	// product of page and page size, kept to 24 bits
	logic [PROD_W-1:0]  prod;
	logic [ROW_W-1:0]   fetch_off_q;

	// tag scan: issue counter, compare stage, hit and victim capture
	logic [USED_W-1:0]  iss_q;
	logic               cmp_vld_s1;
	logic [SLOT_W-1:0]  cmp_idx_s1;
	logic               hit_q;
	logic [SLOT_W-1:0]  hit_slot_q;
	logic [SLOT_W-1:0]  hit_rank_q;
	logic [PAGE_W-1:0]  victim_tag_q;

	// tag ram ports
	logic               ram_we;
	logic [SLOT_W-1:0]  ram_waddr;
	logic [PAGE_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [PAGE_W-1:0]  ram_rdata;

	// result staging and output register
	result_t            res_q;
	result_t            rsp_q;
	logic               rsp_valid_q;

	// replacement choice
	logic [SLOT_W-1:0]  victim_slot;
	logic [SLOT_W-1:0]  best_rank;
	logic [SLOT_W-1:0]  free_slot;
	logic [SLOT_W-1:0]  ins_slot;
	logic               full;

	logic               req_fire;
	logic               is_clear;
	logic               scan_last;
	logic               out_free;

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign is_clear  = (cmd_t'(command) == CMD_CLEAR);
	assign full      = (used_q == USED_W'(MAX_PAGES));
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign scan_last = cmp_vld_s1 && (cmp_idx_s1 == SLOT_W'(MAX_PAGES - 1));

	// one restoring division step
	assign rem_shift = {rem_q, div_q[ROW_W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, ps_q});

	assign prod = PROD_W'(div_q) * PROD_W'(ps_q);

	// least recently used: last valid entry holding the largest rank
	always_comb begin
		victim_slot = '0;
		best_rank   = rank_q[0];
		for (int i = 0; i < MAX_PAGES; i++) begin
			if (valid_q[i] && (rank_q[i] >= best_rank)) begin
				victim_slot = SLOT_W'(i);
				best_rank   = rank_q[i];
			end
		end
	end

	// lowest free entry
	always_comb begin
		free_slot = '0;
		for (int i = MAX_PAGES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
	end

	assign ins_slot = full ? victim_slot : free_slot;

	// tag ram access: writes only on clear-prime and on miss insert
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ins_slot;
		ram_wdata = div_q;
		if (req_fire && is_clear && (row_count_q != '0)) begin
			ram_we    = 1'b1;
			ram_waddr = '0;
			ram_wdata = '0;
		end else if ((state_q == S_UPD) && !hit_q) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re = (state_q == S_SCAN) && (iss_q < USED_W'(MAX_PAGES));

	lrupc_ram #(
		.WIDTH (PAGE_W),
		.DEPTH (MAX_PAGES)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (iss_q[SLOT_W-1:0]),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			page_size_q <= DEFAULT_PAGE_SIZE;
			row_count_q <= '0;
			valid_q     <= '0;
			used_q      <= '0;
			cnt_q       <= '0;
			iss_q       <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < MAX_PAGES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_PAGE_SIZE: page_size_q <= cfg_data[PSIZE_W-1:0];
					REG_ROW_COUNT: row_count_q <= cfg_data[ROW_W-1:0];
					default: ;
				endcase
			end

			// in S_OUT the waiting result takes over the register instead
			if (rsp_valid_q && rsp_ready && (state_q != S_OUT)) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						hit_q <= 1'b0;
						if (is_clear) begin
							// empty the cache, prime page 0 when rows exist
							for (int i = 0; i < MAX_PAGES; i++) begin
								rank_q[i] <= '0;
							end
							if (row_count_q != '0) begin
								valid_q    <= MAX_PAGES'(1);
								used_q     <= USED_W'(1);
							end else begin
								valid_q    <= '0;
								used_q     <= '0;
							end
							state_q <= S_OUT;
						end else if (row_index >= row_count_q) begin
							state_q <= S_OUT;
						end else begin
							cnt_q   <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(ROW_W - 1)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					iss_q      <= '0;
					cmp_vld_s1 <= 1'b0;
					state_q    <= S_SCAN;
				end
				S_SCAN: begin
					if (ram_re) begin
						iss_q      <= iss_q + 1'b1;
						cmp_vld_s1 <= 1'b1;
					end else begin
						cmp_vld_s1 <= 1'b0;
					end
					if (cmp_vld_s1 && !hit_q && valid_q[cmp_idx_s1]
							&& (ram_rdata == div_q)) begin
						hit_q <= 1'b1;
					end
					if (scan_last) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (hit_q) begin
						// entries more recent than the hit age by one
						for (int i = 0; i < MAX_PAGES; i++) begin
							if (valid_q[i] && (rank_q[i] < hit_rank_q)) begin
								rank_q[i] <= rank_q[i] + 1'b1;
							end
						end
						rank_q[hit_slot_q] <= '0;
					end else begin
						// all other entries age; new page is most recent
						for (int i = 0; i < MAX_PAGES; i++) begin
							if (valid_q[i] && (SLOT_W'(i) != ins_slot)) begin
								rank_q[i] <= rank_q[i] + 1'b1;
							end
						end
						rank_q[ins_slot]  <= '0;
						valid_q[ins_slot] <= 1'b1;
						if (!full) begin
							used_q <= used_q + 1'b1;
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					row_q <= row_index;
					div_q <= row_index;
					rem_q <= '0;
					ps_q  <= (page_size_q == '0) ? DEFAULT_PAGE_SIZE : page_size_q;
					if (is_clear) begin
						res_q <= '{in_range: 1'b1, fetch_needed: (row_count_q != '0),
							default: '0};
					end else begin
						res_q <= '0;
					end
				end
			end
			S_DIV: begin
				if (rem_ge) begin
					rem_q <= PSIZE_W'(rem_shift - {1'b0, ps_q});
					div_q <= {div_q[ROW_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_shift[PSIZE_W-1:0];
					div_q <= {div_q[ROW_W-2:0], 1'b0};
				end
			end
			S_MUL: begin
				fetch_off_q <= prod[ROW_W-1:0];
			end
			S_SCAN: begin
				if (ram_re) begin
					cmp_idx_s1 <= iss_q[SLOT_W-1:0];
				end
				if (cmp_vld_s1) begin
					if (!hit_q && valid_q[cmp_idx_s1] && (ram_rdata == div_q)) begin
						hit_slot_q <= cmp_idx_s1;
						hit_rank_q <= rank_q[cmp_idx_s1];
					end
					if (cmp_idx_s1 == victim_slot) begin
						victim_tag_q <= ram_rdata;
					end
				end
			end
			S_UPD: begin
				res_q.in_range       <= 1'b1;
				res_q.hit            <= hit_q;
				res_q.page_number    <= div_q;
				res_q.offset_in_page <= rem_q;
				res_q.fetch_needed   <= !hit_q;
				res_q.fetch_offset   <= hit_q ? '0 : fetch_off_q;
				res_q.evicted_valid  <= !hit_q && full;
				res_q.evicted_page   <= (!hit_q && full) ? victim_tag_q : '0;
			end
			S_OUT: begin
				if (out_free) begin
					rsp_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid      = rsp_valid_q;
	assign in_range       = rsp_q.in_range;
	assign hit            = rsp_q.hit;
	assign page_number    = rsp_q.page_number;
	assign offset_in_page = rsp_q.offset_in_page;
	assign fetch_needed   = rsp_q.fetch_needed;
	assign fetch_offset   = rsp_q.fetch_offset;
	assign evicted_valid  = rsp_q.evicted_valid;
	assign evicted_page   = rsp_q.evicted_page;

	// fill count tracks the valid bits
	a_used_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		used_q == USED_W'($countones(valid_q)))
		else $error("entry count disagrees with valid bits");

	// tag ram is written only on clear or in the update step
	a_ram_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE || state_q == S_UPD))
		else $error("tag ram written outside clear or update");

	// divider leaves quotient and remainder consistent with the row
	a_div_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |->
		((PROD_W'(div_q) * PROD_W'(ps_q) + PROD_W'(rem_q)) == PROD_W'(row_q)
		&& (rem_q < ps_q)))
		else $error("division result inconsistent");

	// a recorded hit always points at a valid entry
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && hit_q) |-> valid_q[hit_slot_q])
		else $error("hit recorded on an invalid entry");

	// a pending result waits while the output register is still occupied
	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && rsp_valid_q && !rsp_ready) |=> (state_q == S_OUT))
		else $error("result overwrote an untaken transaction");

endmodule

// ===== rtl/lrupc_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module lrupc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
